@@ sv/hptm_pkg.sv @@
package hptm_pkg;

   // table geometry
   localparam int GROUP_BITS = 10;
   localparam int SLOT_BITS  = 3;
   localparam int ADDR_BITS  = GROUP_BITS + SLOT_BITS;
   localparam int DEPTH      = 1 << ADDR_BITS;
   localparam int ENTRY_BITS = 64;
   localparam int SCAN_BITS  = SLOT_BITS + 1;

   // word1 flag positions
   localparam int R_POS = 8;
   localparam int C_POS = 7;

   // request commands
   localparam logic [1:0] CMD_MAKE    = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_MISS    = 2'd2;
   localparam logic [1:0] CMD_PRELOAD = 2'd3;

   // response status codes
   localparam logic [2:0] ST_UPDATED  = 3'd0;
   localparam logic [2:0] ST_DELETED  = 3'd1;
   localparam logic [2:0] ST_INS_FREE = 3'd2;
   localparam logic [2:0] ST_INS_EVCT = 3'd3;
   localparam logic [2:0] ST_NOCHANGE = 3'd4;
   localparam logic [2:0] ST_PRESENT  = 3'd5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic load;
      logic scan_en;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic out_free;
   } ctl_sts_type;

endpackage

@@ sv/hptm_if.sv @@
interface hptm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] effective_addr;
   logic [31:0] pte_word1;

   modport source (output valid, command, effective_addr, pte_word1, input ready);
   modport sink (input valid, command, effective_addr, pte_word1, output ready);
endinterface

interface hptm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [9:0] group_index;
   logic [2:0] slot;
   logic       in_secondary;

   modport source (output valid, status, group_index, slot, in_secondary, input ready);
   modport sink (input valid, status, group_index, slot, in_secondary, output ready);
endinterface

@@ sv/hptm_ram.sv @@
module hptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/hptm_ctrl.sv @@
module hptm_ctrl
   import hptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ sv/hptm_dp.sv @@
module hptm_dp
   import hptm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output ctl_sts_type           sts,
   input  logic                  csr_wr_en,
   input  logic [GROUP_BITS-1:0] csr_wr_data,
   input  logic [1:0]            req_command,
   input  logic [31:0]           req_effective_addr,
   input  logic [31:0]           req_pte_word1,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [GROUP_BITS-1:0] rsp_group_index,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_in_secondary
);

   logic [GROUP_BITS-1:0] size_mask_ff;
   logic [ADDR_BITS-1:0]  clr_ff;

   logic [1:0]            cmd_ff;
   logic [3:0]            vsid_ff;
   logic [5:0]            api_ff;
   logic [31:0]           w1_ff;
   logic [GROUP_BITS-1:0] pg_ff, sg_ff;

   logic [SCAN_BITS:0]    scan_ff;
   logic                  ev_ff;
   logic [SCAN_BITS-1:0]  ev_idx_ff;

   logic                  m_ok_ff, f_ok_ff;
   logic [SCAN_BITS-1:0]  m_idx_ff, f_idx_ff;
   logic [31:0]           m_w0_ff;
   logic                  rp_ok_ff, rs_ok_ff, cp_ok_ff, cs_ok_ff;
   logic [SLOT_BITS-1:0]  rp_ff, rs_ff, cp_ff, cs_ff;

   logic                  rsp_valid_ff;
   logic [2:0]            status_ff;
   logic [GROUP_BITS-1:0] group_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic                  sec_ff;

   logic [15:0]           hash;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [31:0]           w0;
   logic                  hit, vld, ev_sec;
   logic [SLOT_BITS-1:0]  ev_slot;

   logic                  do_write, show;
   logic [2:0]            status_in;
   logic [SCAN_BITS-1:0]  loc;
   logic [ENTRY_BITS-1:0] new_entry;
   logic [31:0]           new_w1;
   logic [GROUP_BITS-1:0] loc_group;

   // size mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_mask_ff <= '1;
      end else if (csr_wr_en) begin
         size_mask_ff <= csr_wr_data;
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en && clr_ff != '1) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign sts.clear_done = (clr_ff == '1);
   assign sts.scan_done  = (scan_ff == (SCAN_BITS + 1)'(1 << SCAN_BITS));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // request capture and hash
   assign hash = {12'd0, req_effective_addr[31:28]} ^ req_effective_addr[27:12];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_command;
         vsid_ff <= req_effective_addr[31:28];
         api_ff  <= req_effective_addr[27:22];
         w1_ff   <= req_pte_word1;
         pg_ff   <= hash[GROUP_BITS-1:0] & size_mask_ff;
         sg_ff   <= ~hash[GROUP_BITS-1:0] & size_mask_ff;
      end
   end

   // scan counter: read issue, then evaluation in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         ev_ff   <= 1'b0;
      end else begin
         ev_ff <= cmd.scan_en && !scan_ff[SCAN_BITS];
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (cmd.scan_en && !sts.scan_done) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= scan_ff[SCAN_BITS-1:0];
   end

   assign rd_addr = {scan_ff[SLOT_BITS] ? sg_ff : pg_ff, scan_ff[SLOT_BITS-1:0]};

   // entry evaluation
   assign w0      = rd_data[63:32];
   assign vld     = w0[31];
   assign hit     = vld && w0[30:7] == {20'd0, vsid_ff} && w0[5:0] == api_ff;
   assign ev_sec  = ev_idx_ff[SLOT_BITS];
   assign ev_slot = ev_idx_ff[SLOT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ok_ff  <= 1'b0;
         f_ok_ff  <= 1'b0;
         rp_ok_ff <= 1'b0;
         rs_ok_ff <= 1'b0;
         cp_ok_ff <= 1'b0;
         cs_ok_ff <= 1'b0;
      end else if (ev_ff) begin
         if (hit && !m_ok_ff) begin
            m_ok_ff  <= 1'b1;
            m_idx_ff <= ev_idx_ff;
            m_w0_ff  <= w0;
         end
         if (!vld && !f_ok_ff) begin
            f_ok_ff  <= 1'b1;
            f_idx_ff <= ev_idx_ff;
         end
         if (!rd_data[R_POS]) begin
            if (!ev_sec && !rp_ok_ff) begin
               rp_ok_ff <= 1'b1;
               rp_ff    <= ev_slot;
            end
            if (ev_sec && !rs_ok_ff) begin
               rs_ok_ff <= 1'b1;
               rs_ff    <= ev_slot;
            end
         end
         if (!rd_data[C_POS]) begin
            if (!ev_sec && !cp_ok_ff) begin
               cp_ok_ff <= 1'b1;
               cp_ff    <= ev_slot;
            end
            if (ev_sec && !cs_ok_ff) begin
               cs_ok_ff <= 1'b1;
               cs_ff    <= ev_slot;
            end
         end
      end
   end

   // decision
   always_comb begin
      do_write  = 1'b0;
      status_in = ST_NOCHANGE;
      loc       = '0;
      new_w1    = (cmd_ff == CMD_PRELOAD) ? (w1_ff | (32'd1 << R_POS)) : w1_ff;
      new_entry = '0;
      if (cmd_ff != CMD_MISS && m_ok_ff) begin
         loc = m_idx_ff;
         if (cmd_ff == CMD_PRELOAD) begin
            status_in = ST_PRESENT;
         end else if (w1_ff != '0) begin
            do_write  = 1'b1;
            status_in = ST_UPDATED;
            new_entry = {m_w0_ff, w1_ff};
         end else begin
            do_write  = 1'b1;
            status_in = ST_DELETED;
         end
      end else if (cmd_ff == CMD_UPDATE || (cmd_ff == CMD_MAKE && w1_ff == '0)) begin
         status_in = ST_NOCHANGE;
      end else if (f_ok_ff) begin
         do_write  = 1'b1;
         status_in = ST_INS_FREE;
         loc       = f_idx_ff;
      end else if (cmd_ff == CMD_MAKE) begin
         status_in = ST_NOCHANGE;
      end else begin
         do_write  = 1'b1;
         status_in = ST_INS_EVCT;
         if (rp_ok_ff) begin
            loc = {1'b0, rp_ff};
         end else if (rs_ok_ff) begin
            loc = {1'b1, rs_ff};
         end else if (cp_ok_ff) begin
            loc = {1'b0, cp_ff};
         end else if (cs_ok_ff) begin
            loc = {1'b1, cs_ff};
         end else begin
            loc = '0;
         end
      end
      if (status_in == ST_INS_FREE || status_in == ST_INS_EVCT) begin
         new_entry = {1'b1, 20'd0, vsid_ff, loc[SLOT_BITS], api_ff, new_w1};
      end
   end

   assign loc_group = loc[SLOT_BITS] ? sg_ff : pg_ff;
   assign show      = status_in != ST_NOCHANGE && status_in != ST_PRESENT;

   // table write port
   assign wr_en   = (cmd.clear_en && !sts.clear_done) || cmd.clear_en
                    || (cmd.commit && do_write);
   assign wr_addr = cmd.clear_en ? clr_ff : {loc_group, loc[SLOT_BITS-1:0]};
   assign wr_data = cmd.clear_en ? '0 : new_entry;

   hptm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         group_ff  <= show ? loc_group : '0;
         slot_ff   <= show ? loc[SLOT_BITS-1:0] : '0;
         sec_ff    <= show && loc[SLOT_BITS];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_group_index  = group_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_in_secondary = sec_ff;

endmodule

@@ sv/hashed_page_table_manager.sv @@
// Hashed page table manager: keeps 1024 groups of eight 64-bit entries in one
// table memory and serves one request word at a time. After reset the table is
// swept to zero, one entry per cycle; req_ch.ready stays low during the sweep,
// size mask writes are taken as ever. Each request is accepted, then the sixteen
// entries of the primary and secondary group are read and judged through the
// single read port of the table memory, and then the block decides, writes the
// entry and loads the response register once that register is free. The next
// request is accepted while a response waits to be taken.
module hashed_page_table_manager
   import hptm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [GROUP_BITS-1:0] csr_wr_data,
   hptm_req_if.sink           req_ch,
   hptm_rsp_if.source         rsp_ch
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   // sequencer
   hptm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (ctl_sts),
      .cmd       (ctl_cmd)
   );

   // table and datapath
   hptm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (ctl_sts),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_command        (req_ch.command),
      .req_effective_addr (req_ch.effective_addr),
      .req_pte_word1      (req_ch.pte_word1),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_ch.status),
      .rsp_group_index    (rsp_ch.group_index),
      .rsp_slot           (rsp_ch.slot),
      .rsp_in_secondary   (rsp_ch.in_secondary)
   );

   // no word taken while the table is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      !ctl_sts.clear_done |-> !req_ch.ready)
      else $error("request taken during table clear");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while busy");

   // no location reported for no change or already present
   a_quiet_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_NOCHANGE || rsp_ch.status == ST_PRESENT)
      |-> rsp_ch.group_index == '0 && rsp_ch.slot == '0 && !rsp_ch.in_secondary)
      else $error("location shown with quiet status");

   // response only after a commit
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(ctl_cmd.commit))
      else $error("response without commit");

endmodule
